// ===== hw/rtl/vjc_pkg.sv =====
package vjc_pkg;

    localparam int DEF_VALUE_BITS = 32;
    localparam int DEF_COLOR_BITS = 16;

    localparam int RANGE_MINIMUM_RESET = 0;
    localparam int RANGE_MAXIMUM_RESET = 65535;

    localparam int REG_INDEX_BITS = 2;
    localparam logic [REG_INDEX_BITS-1:0] REG_RANGE_MINIMUM   = 2'd0;
    localparam logic [REG_INDEX_BITS-1:0] REG_RANGE_MAXIMUM   = 2'd1;
    localparam logic [REG_INDEX_BITS-1:0] REG_SWAP_GREEN_BLUE = 2'd2;

    // quarter of the ramp that a sample falls in
    localparam logic [1:0] SEG_RISE_GREEN = 2'd0;
    localparam logic [1:0] SEG_FALL_BLUE  = 2'd1;
    localparam logic [1:0] SEG_RISE_RED   = 2'd2;
    localparam logic [1:0] SEG_FALL_GREEN = 2'd3;

    typedef struct packed {
        logic       valid;
        logic       degenerate;
        logic [1:0] seg;
    } vjc_meta_t;

endpackage

// ===== hw/rtl/value_to_jet_color_ramp.sv =====
// Channel     | Direction | Ports
// ------------+-----------+-------------------------------------------------------
// sample      | in        | start, busy, sample_value
// result      | out       | done, red_level, green_level, blue_level, degenerate_range
// config      | in        | cfg_write, cfg_index, cfg_data
//
// One sample is taken every cycle; busy stays low.
// Each result passes from its sample through six front stages
// (clamp, offset, 3x span, segment, numerator, full-scale product), one division
// cell per colour bit and the output register.
// rst_n clears the pipeline valids and loads the register reset values.
// The receiver cannot stall; done is a one-cycle strobe.
module value_to_jet_color_ramp
    import vjc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COLOR_BITS = DEF_COLOR_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    output logic                         done,
    output logic [COLOR_BITS-1:0]        red_level,
    output logic [COLOR_BITS-1:0]        green_level,
    output logic [COLOR_BITS-1:0]        blue_level,
    output logic                         degenerate_range,
    input  logic                         cfg_write,
    input  logic [REG_INDEX_BITS-1:0]    cfg_index,
    input  logic [VALUE_BITS-1:0]        cfg_data
);

    localparam logic [VALUE_BITS-1:0] MinReset = VALUE_BITS'(RANGE_MINIMUM_RESET);
    localparam logic [VALUE_BITS-1:0] MaxReset = VALUE_BITS'(RANGE_MAXIMUM_RESET);
    localparam logic [COLOR_BITS-1:0] Full     = {COLOR_BITS{1'b1}};

    logic [VALUE_BITS-1:0] range_min_reg;
    logic [VALUE_BITS-1:0] range_max_reg;
    logic                  swap_reg;

    vjc_meta_t             meta_a [0:COLOR_BITS];
    logic [VALUE_BITS-1:0] span_a [0:COLOR_BITS];
    logic [VALUE_BITS-1:0] rem_a  [0:COLOR_BITS];
    logic [COLOR_BITS-1:0] low_a  [0:COLOR_BITS];
    logic [COLOR_BITS-1:0] quo_a  [0:COLOR_BITS];

    logic [VALUE_BITS+COLOR_BITS-1:0] dividend;

    logic                  done_reg;
    logic [COLOR_BITS-1:0] red_reg;
    logic [COLOR_BITS-1:0] green_reg;
    logic [COLOR_BITS-1:0] blue_reg;
    logic                  degen_reg;
    logic [COLOR_BITS-1:0] red_next;
    logic [COLOR_BITS-1:0] green_next;
    logic [COLOR_BITS-1:0] blue_next;
    logic [COLOR_BITS-1:0] ramp_g;
    logic [COLOR_BITS-1:0] ramp_b;
    logic [COLOR_BITS-1:0] level;

    // every cycle is open to a new transaction
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= MinReset;
            range_max_reg <= MaxReset;
            swap_reg      <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RANGE_MINIMUM:   range_min_reg <= cfg_data;
                REG_RANGE_MAXIMUM:   range_max_reg <= cfg_data;
                REG_SWAP_GREEN_BLUE: swap_reg      <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    vjc_front #(
        .VALUE_BITS (VALUE_BITS),
        .COLOR_BITS (COLOR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (start),
        .sample       (sample_value),
        .range_lo     ($signed(range_min_reg)),
        .range_hi     ($signed(range_max_reg)),
        .meta_out     (meta_a[0]),
        .span_out     (span_a[0]),
        .dividend_out (dividend)
    );

    // upper part of the dividend is already below the span
    assign rem_a[0] = dividend[VALUE_BITS+COLOR_BITS-1:COLOR_BITS];
    assign low_a[0] = dividend[COLOR_BITS-1:0];
    assign quo_a[0] = '0;

    for (genvar k = 0; k < COLOR_BITS; k++)
    begin : g_cell
        vjc_div_cell #(
            .VALUE_BITS (VALUE_BITS),
            .COLOR_BITS (COLOR_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .meta_in  (meta_a[k]),
            .span_in  (span_a[k]),
            .rem_in   (rem_a[k]),
            .low_in   (low_a[k]),
            .quo_in   (quo_a[k]),
            .meta_out (meta_a[k+1]),
            .span_out (span_a[k+1]),
            .rem_out  (rem_a[k+1]),
            .low_out  (low_a[k+1]),
            .quo_out  (quo_a[k+1])
        );
    end

    always_comb
    begin
        level    = quo_a[COLOR_BITS];
        red_next = '0;
        ramp_g   = Full;
        ramp_b   = '0;
        unique case (meta_a[COLOR_BITS].seg)
            SEG_RISE_GREEN:
            begin
                ramp_g = level;
                ramp_b = Full;
            end
            SEG_FALL_BLUE:
            begin
                ramp_b = level;
            end
            SEG_RISE_RED:
            begin
                red_next = level;
            end
            SEG_FALL_GREEN:
            begin
                red_next = Full;
                ramp_g   = level;
            end
            default:
            begin
                red_next = '0;
            end
        endcase
        green_next = swap_reg ? ramp_b : ramp_g;
        blue_next  = swap_reg ? ramp_g : ramp_b;
        if (meta_a[COLOR_BITS].degenerate)
        begin
            red_next   = Full;
            green_next = Full;
            blue_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= meta_a[COLOR_BITS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        degen_reg <= meta_a[COLOR_BITS].degenerate;
    end

    assign done             = done_reg;
    assign red_level        = red_reg;
    assign green_level      = green_reg;
    assign blue_level       = blue_reg;
    assign degenerate_range = degen_reg;

endmodule

// ===== hw/rtl/vjc_div_cell.sv =====
module vjc_div_cell
    import vjc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COLOR_BITS = DEF_COLOR_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  vjc_meta_t             meta_in,
    input  logic [VALUE_BITS-1:0] span_in,
    input  logic [VALUE_BITS-1:0] rem_in,
    input  logic [COLOR_BITS-1:0] low_in,
    input  logic [COLOR_BITS-1:0] quo_in,
    output vjc_meta_t             meta_out,
    output logic [VALUE_BITS-1:0] span_out,
    output logic [VALUE_BITS-1:0] rem_out,
    output logic [COLOR_BITS-1:0] low_out,
    output logic [COLOR_BITS-1:0] quo_out
);

    vjc_meta_t             meta_reg;
    logic [VALUE_BITS-1:0] span_reg;
    logic [VALUE_BITS-1:0] rem_reg;
    logic [VALUE_BITS-1:0] rem_next;
    logic [COLOR_BITS-1:0] low_reg;
    logic [COLOR_BITS-1:0] quo_reg;
    logic [COLOR_BITS-1:0] quo_next;
    logic [VALUE_BITS:0]   shifted;
    logic [VALUE_BITS+1:0] trial;
    logic                  borrow;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted  = {rem_in, low_in[COLOR_BITS-1]};
        trial    = {1'b0, shifted} - {2'b00, span_in};
        borrow   = trial[VALUE_BITS+1];
        rem_next = borrow ? shifted[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
        quo_next = {quo_in[COLOR_BITS-2:0], ~borrow};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_reg <= '0;
        end
        else
        begin
            meta_reg <= meta_in;
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_in;
        rem_reg  <= rem_next;
        low_reg  <= {low_in[COLOR_BITS-2:0], 1'b0};
        quo_reg  <= quo_next;
    end

    assign meta_out = meta_reg;
    assign span_out = span_reg;
    assign rem_out  = rem_reg;
    assign low_out  = low_reg;
    assign quo_out  = quo_reg;

endmodule

// ===== hw/rtl/vjc_front.sv =====
module vjc_front
    import vjc_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int COLOR_BITS = DEF_COLOR_BITS
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic signed [VALUE_BITS-1:0]     sample,
    input  logic signed [VALUE_BITS-1:0]     range_lo,
    input  logic signed [VALUE_BITS-1:0]     range_hi,
    output vjc_meta_t                        meta_out,
    output logic [VALUE_BITS-1:0]            span_out,
    output logic [VALUE_BITS+COLOR_BITS-1:0] dividend_out
);

    localparam int XW = VALUE_BITS + 2;

    // stage A: clamp
    vjc_meta_t                    meta_a_reg;
    vjc_meta_t                    meta_a_next;
    logic signed [VALUE_BITS-1:0] clamp_a_reg;
    logic signed [VALUE_BITS-1:0] clamp_a_next;
    // stage B: offset and span
    vjc_meta_t                    meta_b_reg;
    logic [VALUE_BITS-1:0]        x_b_reg;
    logic [VALUE_BITS-1:0]        span_b_reg;
    // stage C: 4x and 3d
    vjc_meta_t                    meta_c_reg;
    logic [XW-1:0]                x4_c_reg;
    logic [VALUE_BITS-1:0]        span_c_reg;
    logic [XW-1:0]                span3_c_reg;
    logic [XW-1:0]                span3_c_next;
    // stage D: segment
    vjc_meta_t                    meta_d_reg;
    vjc_meta_t                    meta_d_next;
    logic [XW-1:0]                x4_d_reg;
    logic [VALUE_BITS-1:0]        span_d_reg;
    // stage E: ramp numerator
    vjc_meta_t                    meta_e_reg;
    logic [VALUE_BITS-1:0]        num_e_reg;
    logic [VALUE_BITS-1:0]        num_e_next;
    logic [VALUE_BITS-1:0]        span_e_reg;
    // stage F: numerator times full scale
    vjc_meta_t                    meta_f_reg;
    logic [VALUE_BITS+COLOR_BITS-1:0] dividend_f_reg;
    logic [VALUE_BITS+COLOR_BITS-1:0] dividend_f_next;
    logic [VALUE_BITS-1:0]        span_f_reg;

    logic [XW-1:0] span_w;
    logic [XW-1:0] span2_w;
    logic [XW-1:0] span4_w;
    logic [XW-1:0] num_w;

    always_comb
    begin
        meta_a_next.valid      = in_valid;
        meta_a_next.degenerate = (range_hi <= range_lo);
        meta_a_next.seg        = SEG_RISE_GREEN;
        if (sample < range_lo)
        begin
            clamp_a_next = range_lo;
        end
        else if (sample > range_hi)
        begin
            clamp_a_next = range_hi;
        end
        else
        begin
            clamp_a_next = sample;
        end
    end

    always_comb
    begin
        span3_c_next = {2'b00, span_b_reg} + {1'b0, span_b_reg, 1'b0};
    end

    always_comb
    begin
        span_w      = {2'b00, span_c_reg};
        span2_w     = {1'b0, span_c_reg, 1'b0};
        meta_d_next = meta_c_reg;
        if (x4_c_reg < span_w)
        begin
            meta_d_next.seg = SEG_RISE_GREEN;
        end
        else if (x4_c_reg < span2_w)
        begin
            meta_d_next.seg = SEG_FALL_BLUE;
        end
        else if (x4_c_reg < span3_c_reg)
        begin
            meta_d_next.seg = SEG_RISE_RED;
        end
        else
        begin
            meta_d_next.seg = SEG_FALL_GREEN;
        end
    end

    always_comb
    begin
        span4_w = {span_d_reg, 2'b00};
        unique case (meta_d_reg.seg)
            SEG_RISE_GREEN: num_w = x4_d_reg;
            SEG_FALL_BLUE:  num_w = {1'b0, span_d_reg, 1'b0} - x4_d_reg;
            SEG_RISE_RED:   num_w = x4_d_reg - {1'b0, span_d_reg, 1'b0};
            SEG_FALL_GREEN: num_w = span4_w - x4_d_reg;
            default:        num_w = '0;
        endcase
        // never above the span, so the low bits hold it
        num_e_next = num_w[VALUE_BITS-1:0];
    end

    always_comb
    begin
        dividend_f_next = {num_e_reg, {COLOR_BITS{1'b0}}}
                          - {{COLOR_BITS{1'b0}}, num_e_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_a_reg <= '0;
            meta_b_reg <= '0;
            meta_c_reg <= '0;
            meta_d_reg <= '0;
            meta_e_reg <= '0;
            meta_f_reg <= '0;
        end
        else
        begin
            meta_a_reg <= meta_a_next;
            meta_b_reg <= meta_a_reg;
            meta_c_reg <= meta_b_reg;
            meta_d_reg <= meta_d_next;
            meta_e_reg <= meta_d_reg;
            meta_f_reg <= meta_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        clamp_a_reg    <= clamp_a_next;
        x_b_reg        <= clamp_a_reg - range_lo;
        span_b_reg     <= range_hi - range_lo;
        x4_c_reg       <= {x_b_reg, 2'b00};
        span_c_reg     <= span_b_reg;
        span3_c_reg    <= span3_c_next;
        x4_d_reg       <= x4_c_reg;
        span_d_reg     <= span_c_reg;
        num_e_reg      <= num_e_next;
        span_e_reg     <= span_d_reg;
        dividend_f_reg <= dividend_f_next;
        span_f_reg     <= span_e_reg;
    end

    assign meta_out     = meta_f_reg;
    assign span_out     = span_f_reg;
    assign dividend_out = dividend_f_reg;

endmodule
